### src/cgi_pkg.sv
`timescale 1ns / 1ps

package cgi_pkg;

	localparam int CHAN_W      = 8;
	localparam int NUM_CHAN    = 4;
	localparam int RGBA_W      = CHAN_W * NUM_CHAN;
	localparam int STOP_W      = 48;
	localparam int KEY_LSB     = 32;
	localparam int STOP_KEY_W  = 16;
	localparam int COUNT_W     = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_FIRST = 3'd1;

	// lane order matches the stop register packing, alpha in the low byte
	localparam int CH_ALPHA = 0;
	localparam int CH_BLUE  = 1;
	localparam int CH_GREEN = 2;
	localparam int CH_RED   = 3;

	typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rgba_t;

	localparam rgba_t WHITE_RGBA = 32'hFFFF_FFFF;

endpackage

### src/cgi_front.sv
`timescale 1ns / 1ps

module cgi_front #(
	parameter int MAX_STOPS = 6,
	parameter int KEY_BITS  = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [cgi_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [cgi_pkg::STOP_W-1:0]             cfg_data,
	input  logic                                   key_valid,
	output logic                                   key_ready,
	input  logic [KEY_BITS-1:0]                    key_in,
	output logic                                   push,
	input  logic                                   full,
	output logic [2*cgi_pkg::RGBA_W+2*KEY_BITS-1:0] item
);
	import cgi_pkg::*;

	localparam int IDX_W = $clog2(MAX_STOPS);

	typedef struct packed {
		rgba_t                cb;
		rgba_t                cn;
		logic [KEY_BITS-1:0]  den;
		logic [KEY_BITS-1:0]  t;
	} item_t;

	logic [COUNT_W-1:0]  count_q;
	logic [STOP_W-1:0]   stops_q [MAX_STOPS];
	logic [KEY_BITS-1:0] skey [MAX_STOPS];
	rgba_t               scol [MAX_STOPS];

	logic                vld_s1;
	logic [KEY_BITS-1:0] key_s1;

	logic [COUNT_W-1:0]  cnt;
	logic [IDX_W-1:0]    last;
	logic [IDX_W-1:0]    hi;
	logic [IDX_W-1:0]    lo;
	item_t               it;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < MAX_STOPS; i++) begin
				stops_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_STOP_COUNT) begin
				count_q <= cfg_data[COUNT_W-1:0];
			end else if (cfg_index >= REG_STOP_FIRST &&
					cfg_index < REG_STOP_FIRST + CFG_IDX_W'(MAX_STOPS)) begin
				stops_q[IDX_W'(cfg_index - REG_STOP_FIRST)] <= cfg_data;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_STOPS; i++) begin
			skey[i] = KEY_BITS'(stops_q[i][KEY_LSB +: STOP_KEY_W]);
			scol[i] = rgba_t'(stops_q[i][RGBA_W-1:0]);
		end
	end

	assign key_ready = !vld_s1 || !full;
	assign push      = vld_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (key_valid && key_ready) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (key_valid && key_ready) begin
			key_s1 <= key_in;
		end
	end

	// flat results go through the divider as color * 1 / 1
	always_comb begin
		cnt  = (count_q > COUNT_W'(MAX_STOPS)) ? COUNT_W'(MAX_STOPS) : count_q;
		last = IDX_W'(cnt - COUNT_W'(1));
		hi   = last;
		for (int i = MAX_STOPS - 1; i >= 1; i--) begin
			if (COUNT_W'(i) < cnt && key_s1 <= skey[i]) begin
				hi = IDX_W'(i);
			end
		end
		lo = hi - IDX_W'(1);

		it.cb  = WHITE_RGBA;
		it.cn  = WHITE_RGBA;
		it.den = KEY_BITS'(1);
		it.t   = '0;
		if (cnt == '0) begin
			it.cb = WHITE_RGBA;
			it.cn = WHITE_RGBA;
		end else if (key_s1 <= skey[0]) begin
			it.cb = scol[0];
			it.cn = scol[0];
		end else if (key_s1 >= skey[last]) begin
			it.cb = scol[last];
			it.cn = scol[last];
		end else begin
			it.cb  = scol[lo];
			it.cn  = scol[hi];
			it.den = skey[hi] - skey[lo];
			it.t   = key_s1 - skey[lo];
		end
	end

	assign item = it;

endmodule

### src/cgi_queue.sv
`timescale 1ns / 1ps

module cgi_queue #(
	parameter int W = 96
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         pop,
	output logic         rd_valid,
	output logic [W-1:0] rd_data
);
	import cgi_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign full     = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("request pushed into full queue");
`endif

endmodule

### src/cgi_back.sv
`timescale 1ns / 1ps

module cgi_back #(
	parameter int KEY_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    q_valid,
	input  logic [2*cgi_pkg::RGBA_W+2*KEY_BITS-1:0] q_item,
	output logic                                    pop,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output cgi_pkg::rgba_t                          out_color
);
	import cgi_pkg::*;

	localparam int NUM_W = KEY_BITS + CHAN_W;
	localparam int NSTEP = CHAN_W;

	typedef struct packed {
		rgba_t                cb;
		rgba_t                cn;
		logic [KEY_BITS-1:0]  den;
		logic [KEY_BITS-1:0]  t;
	} item_t;

	item_t                          it;
	logic                           adv;
	logic [KEY_BITS-1:0]            dt;
	logic [NUM_CHAN-1:0][NUM_W-1:0] num;

	logic                           vld_s [1:NSTEP+1];
	logic [NUM_CHAN-1:0][NUM_W-1:0] rem_s [1:NSTEP];
	logic [KEY_BITS-1:0]            den_s [1:NSTEP];
	rgba_t                          quo_s [2:NSTEP+1];

	assign it        = q_item;
	assign adv       = !vld_s[NSTEP+1] || out_ready;
	assign pop       = adv && q_valid;
	assign out_valid = vld_s[NSTEP+1];
	assign out_color = quo_s[NSTEP+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NSTEP + 1; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= q_valid;
			for (int k = 2; k <= NSTEP + 1; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// cb*(den-t) + cn*t + den/2, bounded below 256*den
	assign dt = it.den - it.t;

	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			num[c] = NUM_W'(it.cb[c]) * NUM_W'(dt) + NUM_W'(it.cn[c]) * NUM_W'(it.t)
				+ NUM_W'(it.den >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[1] <= num;
			den_s[1] <= it.den;
		end
	end

	// restoring divide, one quotient bit per stage, MSB first
	for (genvar k = 1; k <= NSTEP; k++) begin : g_div
		localparam int B = NSTEP - k;

		logic [NUM_W-1:0]    dsh;
		logic [NUM_CHAN-1:0] ge;
		rgba_t               quo_prev;
		rgba_t               quo_nx;

		if (k == 1) begin : g_first
			assign quo_prev = '0;
		end else begin : g_next
			assign quo_prev = quo_s[k];
		end

		always_comb begin
			dsh    = NUM_W'(den_s[k]) << B;
			quo_nx = quo_prev;
			for (int c = 0; c < NUM_CHAN; c++) begin
				ge[c]        = rem_s[k][c] >= dsh;
				quo_nx[c][B] = ge[c];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				quo_s[k+1] <= quo_nx;
			end
		end

		if (k < NSTEP) begin : g_rem
			logic [NUM_CHAN-1:0][NUM_W-1:0] rem_nx;

			always_comb begin
				for (int c = 0; c < NUM_CHAN; c++) begin
					rem_nx[c] = ge[c] ? rem_s[k][c] - dsh : rem_s[k][c];
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[k+1] <= rem_nx;
					den_s[k+1] <= den_s[k];
				end
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[1] |-> den_s[1] != '0)
		else $error("zero divisor entered divider");

	for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chk
		assert property (@(posedge clk) disable iff (!arst_n)
			vld_s[NSTEP] |-> rem_s[NSTEP][c] < (NUM_W'(den_s[NSTEP]) << 1))
			else $error("partial remainder out of range, quotient overflow");
	end
`endif

endmodule

### src/color_gradient_interpolator.sv
`timescale 1ns / 1ps

// Maps a key (Q0.KEY_BITS) to an RGBA color from a gradient of up to MAX_STOPS
// stops. Register 0 holds the stop count (0 gives opaque white), registers
// 1..6 hold the stops as key[47:32], red[31:24], green[23:16], blue[15:8],
// alpha[7:0], in ascending key order. Keys at or outside the end stops take
// the end color; others are interpolated per channel and rounded to nearest.
// One request is accepted per clock and one result delivered per clock
// while the output is not back-pressured; a request passes one classify
// stage, the 4-entry queue whose output feeds the multipliers, and an
// 8-stage restoring divider that yields one quotient bit per stage. Write
// configuration only while no request is in flight.
module color_gradient_interpolator #(
	parameter int MAX_STOPS = 6,
	parameter int KEY_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [cgi_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cgi_pkg::STOP_W-1:0]           cfg_data,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [((KEY_BITS+7)/8)*8-1:0]        s_axis_tdata,  // sample_key
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [cgi_pkg::RGBA_W-1:0]           m_axis_tdata   // alpha[31:24], blue, green, red[7:0]
);
	import cgi_pkg::*;

	localparam int ITEM_W = 2 * RGBA_W + 2 * KEY_BITS;

	logic              push;
	logic              full;
	logic [ITEM_W-1:0] wr_item;
	logic              pop;
	logic              rd_valid;
	logic [ITEM_W-1:0] rd_item;
	rgba_t             color;

	cgi_front #(
		.MAX_STOPS (MAX_STOPS),
		.KEY_BITS  (KEY_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key_valid (s_axis_tvalid),
		.key_ready (s_axis_tready),
		.key_in    (s_axis_tdata[KEY_BITS-1:0]),
		.push      (push),
		.full      (full),
		.item      (wr_item)
	);

	cgi_queue #(
		.W (ITEM_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (wr_item),
		.full     (full),
		.pop      (pop),
		.rd_valid (rd_valid),
		.rd_data  (rd_item)
	);

	cgi_back #(
		.KEY_BITS (KEY_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (rd_valid),
		.q_item    (rd_item),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_color (color)
	);

	assign m_axis_tdata = {color[CH_ALPHA], color[CH_BLUE], color[CH_GREEN], color[CH_RED]};

endmodule
